FILE: rtl/length_checksum_frame_transmitter_defines.svh
// Shared assertion macros
`ifndef LENGTH_CHECKSUM_FRAME_TRANSMITTER_DEFINES_SVH
`define LENGTH_CHECKSUM_FRAME_TRANSMITTER_DEFINES_SVH

// checked outside reset
`define LCFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge
`define LCFT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/lcft_pkg.sv
`default_nettype none
package lcft_pkg;

  localparam int BYTE_W    = 8;
  localparam int MAX_BURST = 4;
  localparam int IDX_W     = $clog2(MAX_BURST);

  // up to four bytes caused by one input transaction
  typedef struct packed {
    logic [MAX_BURST-1:0][BYTE_W-1:0] bytes;
    logic [IDX_W-1:0]                 last_idx;
    logic                             has_checksum;
  } burst_t;

endpackage
`default_nettype wire

FILE: rtl/lcft_framer.sv
`default_nettype none
`include "length_checksum_frame_transmitter_defines.svh"
module lcft_framer (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic                      in_ready,
  input  wire logic [lcft_pkg::BYTE_W-1:0] payload_byte,
  input  wire logic [lcft_pkg::BYTE_W-1:0] frame_length,
  input  wire logic [lcft_pkg::BYTE_W-1:0] start_byte,
  output lcft_pkg::burst_t               burst
);
  import lcft_pkg::*;

  logic              in_frame;
  logic [BYTE_W-1:0] bytes_sent;
  logic [BYTE_W-1:0] running_sum;
  logic [BYTE_W-1:0] frame_total;

  logic              accept;
  logic [BYTE_W-1:0] sum_next;
  logic [BYTE_W-1:0] sent_next;
  logic [BYTE_W-1:0] total_next;
  logic [BYTE_W-1:0] checksum;
  logic              done;

  assign accept = in_valid && in_ready;

  always_comb begin
    if (!in_frame) begin
      sum_next   = payload_byte;
      sent_next  = BYTE_W'(1);
      total_next = frame_length;
    end else begin
      sum_next   = running_sum + payload_byte;
      sent_next  = bytes_sent + BYTE_W'(1);
      total_next = frame_total;
    end
    done     = (sent_next == total_next);
    checksum = BYTE_W'(0) - sum_next;

    burst.has_checksum = done;
    if (!in_frame) begin
      burst.bytes    = {checksum, payload_byte, frame_length, start_byte};
      burst.last_idx = done ? IDX_W'(3) : IDX_W'(2);
    end else begin
      burst.bytes    = {BYTE_W'(0), BYTE_W'(0), checksum, payload_byte};
      burst.last_idx = done ? IDX_W'(1) : IDX_W'(0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      bytes_sent  <= '0;
      running_sum <= '0;
      frame_total <= '0;
    end else if (accept) begin
      in_frame    <= !done;
      bytes_sent  <= sent_next;
      running_sum <= sum_next;
      frame_total <= total_next;
    end
  end

  `LCFT_ASSERT(a_close_on_done, accept && done |=> !in_frame, "frame not closed")
  `LCFT_ASSERT(a_open_count, accept && !in_frame && !done |=> in_frame && bytes_sent == BYTE_W'(1),
    "frame open count wrong")
  `LCFT_ASSERT(a_hold_idle, !accept |=> $stable(in_frame) && $stable(running_sum),
    "state moved without transaction")

endmodule
`default_nettype wire

FILE: rtl/lcft_serializer.sv
`default_nettype none
`include "length_checksum_frame_transmitter_defines.svh"
module lcft_serializer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire lcft_pkg::burst_t            burst,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [lcft_pkg::BYTE_W-1:0]      out_byte,
  output logic                             out_last
);
  import lcft_pkg::*;

  burst_t           held;
  logic             held_valid;
  logic [IDX_W-1:0] idx;
  logic             out_load;
  logic             advance;
  logic             at_last;
  logic             load;

  assign out_load = !out_valid || out_ready;
  assign at_last  = (idx == held.last_idx);
  assign advance  = held_valid && out_load;
  assign in_ready = !held_valid || (out_load && at_last);
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      idx        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (load) begin
        held_valid <= 1'b1;
        idx        <= '0;
      end else if (advance) begin
        held_valid <= !at_last;
        idx        <= idx + IDX_W'(1);
      end
      if (out_load) begin
        out_valid <= held_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= burst;
    end
    if (advance) begin
      out_byte <= held.bytes[idx];
      out_last <= held.has_checksum && at_last;
    end
  end

  `LCFT_ASSERT(a_idx_range, held_valid |-> idx <= held.last_idx, "index past burst end")
  `LCFT_ASSERT(a_load_start, load |=> held_valid && idx == IDX_W'(0), "burst not loaded")
  `LCFT_ASSERT(a_stall_hold, held_valid && !out_load |=> $stable(idx) && held_valid,
    "burst advanced under stall")

endmodule
`default_nettype wire

FILE: rtl/length_checksum_frame_transmitter.sv
`default_nettype none
// Frame transmitter: wraps payload bytes as start, length, payload, checksum.
// Input: s_axis_tdata = {frame_length, payload_byte}; frame_length is read
// only on the transaction that opens a frame (0 means 256 payload bytes).
// Output: m_axis_tdata = tx_byte, m_axis_tlast = end_of_frame (checksum).
// Checksum is the two's complement of the 8-bit payload sum.
// start_byte is written by start_byte_we / start_byte_wdata; it is sampled
// when a frame opens.
// A transaction's first byte passes the burst register, then the output register.
// Throughput: one output byte per cycle while m_axis_tready is high. A transaction
// produces 1 to 4 bytes (start, length, data, checksum) and holds the input until
// its last byte moves to the output register; mid-frame payload bytes go through at one per cycle unless stalled.
// The output register lets a new transaction enter while the last byte of the
// previous one still waits on m_axis_tready.
// Reset (rst, synchronous) clears start_byte to 0, closes any open frame and
// drops all pending bytes. When the receiver stalls, the output holds and
// s_axis_tready falls once the burst register is full.
module length_checksum_frame_transmitter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start_byte_we,
  input  wire logic [7:0]  start_byte_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [7:0] payload_byte, [15:8] frame_length
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] tx_byte
  output logic             m_axis_tlast    // end_of_frame
);
  import lcft_pkg::*;

  logic [BYTE_W-1:0] start_byte;
  burst_t            burst;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= '0;
    end else if (start_byte_we) begin
      start_byte <= start_byte_wdata;
    end
  end

  lcft_framer u_framer (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .payload_byte (s_axis_tdata[7:0]),
    .frame_length (s_axis_tdata[15:8]),
    .start_byte   (start_byte),
    .burst        (burst)
  );

  lcft_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .burst     (burst),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule
`default_nettype wire

FILE: sim/tb_length_checksum_frame_transmitter.sv
`timescale 1ns / 1ps

module tb_length_checksum_frame_transmitter;

  localparam int RX_HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES  = 6;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       end_of_frame;
  } tx_item_t;

  // Tracks the framing state and holds the bytes the transmitter still owes.
  class frame_scoreboard;
    bit [7:0] start_byte;
    bit       open_frame;
    bit [7:0] payload_count;
    bit [7:0] payload_sum;
    bit [7:0] frame_len;
    tx_item_t pending_tx[$];
    int errors;
    int inputs_seen;
    int frames_closed;
    int bytes_checked;

    function void set_start(bit [7:0] value);
      start_byte = value;
    endfunction

    function void push(bit [7:0] tx_byte, bit eof);
      tx_item_t item;
      item.tx_byte      = tx_byte;
      item.end_of_frame = eof;
      pending_tx.push_back(item);
    endfunction

    function void note_input(bit [7:0] payload, bit [7:0] len);
      inputs_seen++;
      if (!open_frame) begin
        frame_len     = len;
        payload_count = 8'd0;
        payload_sum   = 8'd0;
        open_frame    = 1'b1;
        push(start_byte, 1'b0);
        push(len, 1'b0);
      end
      push(payload, 1'b0);
      payload_sum   = payload_sum + payload;
      payload_count = payload_count + 8'd1;
      if (payload_count == frame_len) begin
        push(~payload_sum + 8'd1, 1'b1);
        open_frame = 1'b0;
        frames_closed++;
      end
    endfunction

    function void check_tx(logic [7:0] tx_byte, logic eof);
      tx_item_t exp_item;
      bytes_checked++;
      if (pending_tx.size() == 0) begin
        $error("unexpected output transaction: tx_byte %02h end_of_frame %0b", tx_byte, eof);
        errors++;
        return;
      end
      exp_item = pending_tx.pop_front();
      if (exp_item.tx_byte !== tx_byte) begin
        $error("tx_byte mismatch: expected %02h, actual %02h", exp_item.tx_byte, tx_byte);
        errors++;
      end
      if (exp_item.end_of_frame !== eof) begin
        $error("end_of_frame mismatch: expected %0b, actual %0b",
               exp_item.end_of_frame, eof);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start_byte_we = 1'b0;
  logic [7:0]  start_byte_wdata = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = 16'd0;  // [7:0] payload_byte, [15:8] frame_length
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;          // [7:0] tx_byte
  logic        m_axis_tlast;          // end_of_frame

  bit tx_idle;
  bit rx_idle;
  bit rx_hold;

  frame_scoreboard frames;

  length_checksum_frame_transmitter DUT (
    .clk              (clk),
    .rst              (rst),
    .start_byte_we    (start_byte_we),
    .start_byte_wdata (start_byte_wdata),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tlast     (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      frames.check_tx(m_axis_tdata, m_axis_tlast);
    end
  end

  // receiver: random stalls per transaction, plus one long hold on request
  initial begin
    int wait_cycles;
    @(negedge rst);
    forever begin
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
      wait_cycles = rx_idle ? $urandom_range(0, 9) : 0;
      if (wait_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
    end
  end

  function automatic bit [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0: rand_byte = 8'h00;
      1: rand_byte = 8'hFF;
      default: rand_byte = 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_item(bit [7:0] payload, bit [7:0] len);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= {len, payload};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    frames.note_input(payload, len);
  endtask

  // len 0 wraps the payload counter: 256 bytes
  task automatic send_frame(bit [7:0] len);
    int n;
    n = (len == 8'd0) ? 256 : len;
    for (int i = 0; i < n; i++) begin
      send_item(rand_byte(), (i == 0) ? len : 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (frames.pending_tx.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_start(bit [7:0] value);
    start_byte_we    <= 1'b1;
    start_byte_wdata <= value;
    @(posedge clk);
    start_byte_we <= 1'b0;
    frames.set_start(value);
    @(posedge clk);
  endtask

  initial begin
    int phase_start;
    frames = new();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed: reset start byte, one-byte frames, wrap of the sum
    send_item(8'h00, 8'd1);
    drain();
    write_start(8'hFF);
    send_item(8'hFF, 8'd1);
    drain();
    write_start(8'hA5);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_item(8'h01, 8'd3);
    send_item(8'h80, 8'hFF);
    send_item(8'h7F, 8'h00);
    send_item(8'hFF, 8'd2);
    send_item(8'hFF, 8'hFF);
    send_item(8'h55, 8'd255 - 8'd250);
    send_item(8'hAA, 8'h00);
    send_item(8'h0F, 8'hFF);
    send_item(8'hF0, 8'h00);
    send_item(8'h33, 8'h01);
    drain();

    // start byte changed in the middle of an open frame
    send_item(8'h12, 8'd4);
    send_item(8'h34, 8'hAA);
    drain();
    write_start(8'h3C);
    send_item(8'h56, 8'h55);
    send_item(8'h78, 8'h01);
    send_item(8'h9A, 8'd1);
    drain();

    // random phases, one start byte each
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: write_start(8'h00);
        1: write_start(8'hFF);
        default: write_start(8'($urandom_range(0, 255)));
      endcase
      tx_idle = $urandom_range(0, 1);
      rx_idle = $urandom_range(0, 1);
      phase_start = frames.inputs_seen;
      if (p == 2) begin
        // long receiver hold while the sender keeps offering
        tx_idle = 1'b0;
        rx_hold = 1'b1;
        while (frames.inputs_seen - phase_start < 40) begin
          send_frame(8'($urandom_range(1, 6)));
        end
      end else if (p == 3) begin
        send_frame(8'd0);
      end else begin
        while (frames.inputs_seen - phase_start < 9) begin
          send_frame(($urandom_range(0, 3) == 0) ? 8'd1 : 8'($urandom_range(2, 12)));
        end
      end
      drain();
    end

    $display("Sent %0d payload bytes in %0d frames, checked %0d output bytes",
             frames.inputs_seen, frames.frames_closed, frames.bytes_checked);
    $display("Covered start byte extremes, short and zero-length frames, mid-frame start change, backpressure");
    if (frames.errors == 0 && frames.pending_tx.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lcft_pkg.sv
rtl/lcft_framer.sv
rtl/lcft_serializer.sv
rtl/length_checksum_frame_transmitter.sv
sim/tb_length_checksum_frame_transmitter.sv
